FILE: hw/rtl/uer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Phase and status codes, register indexes, reset values and the result item.
// ----------------------------------------------------------------------------
package uer_pkg;

    // Default counter width
    localparam int COUNT_WIDTH_DEF = 16;

    // Register widths and the configuration port
    localparam int TRIG_W    = 10;
    localparam int TIMEOUT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIMEOUT  = 2'd2;

    // Register reset values
    localparam logic [TRIG_W-1:0]    TRIGGER_TICKS_RST = 10'd20;
    localparam logic [TIMEOUT_W-1:0] RISE_TIMEOUT_RST  = 16'd10000;
    localparam logic [TIMEOUT_W-1:0] HIGH_TIMEOUT_RST  = 16'd60000;

    // Distance scaling: 1114/65536 cm per tick, result in Q8 centimetres
    localparam int SCALE_W    = 11;
    localparam int SCALE_Q16  = 1114;
    localparam int DIST_W     = 18;
    localparam int DIST_MAX   = 261119;
    localparam int DIST_SHIFT = 8;

    // Stream payload widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_HIGH = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_NO_ECHO  = 2'd2
    } status_t;

    // Configuration register set
    typedef struct packed {
        logic [TRIG_W-1:0]    trigger_ticks;
        logic [TIMEOUT_W-1:0] rise_timeout;
        logic [TIMEOUT_W-1:0] high_timeout;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic [DIST_W-1:0] distance_q8;
        logic [1:0]        status;
        logic              done_res;
        logic              busy_res;
        logic              trigger_level;
    } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/uer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_core: ranging state machine
// Advances phase and tick counter on each accepted tick and forms its result.
// ----------------------------------------------------------------------------
module uer_core #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire uer_pkg::cfg_t    cfg,
    input  wire logic             take,
    input  wire logic             start_req,
    input  wire logic             echo_level,
    output uer_pkg::result_t      res
);

    localparam int CMP_W  = (COUNT_WIDTH > uer_pkg::TIMEOUT_W) ? COUNT_WIDTH
                                                                : uer_pkg::TIMEOUT_W;
    localparam int PROD_W = COUNT_WIDTH + uer_pkg::SCALE_W;
    localparam int SC_W   = (PROD_W - uer_pkg::DIST_SHIFT > uer_pkg::DIST_W)
                            ? PROD_W - uer_pkg::DIST_SHIFT : uer_pkg::DIST_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    uer_pkg::phase_t          phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;

    logic [COUNT_WIDTH-1:0]   bumped;
    logic                     at_max;
    logic [CMP_W-1:0]         bumped_x;
    logic [CMP_W-1:0]         trig_x;
    logic [CMP_W-1:0]         rise_x;
    logic [CMP_W-1:0]         high_x;
    logic [PROD_W-1:0]        prod;
    logic [SC_W-1:0]          scaled;
    logic [uer_pkg::DIST_W-1:0] dist_sat;

    // Saturating increment of the tick counter
    always_comb
    begin
        bumped   = (count_reg == CNT_MAX) ? CNT_MAX : count_reg + CNT_ONE;
        at_max   = (bumped == CNT_MAX);
        bumped_x = CMP_W'(bumped);
        trig_x   = CMP_W'(cfg.trigger_ticks);
        rise_x   = CMP_W'(cfg.rise_timeout);
        high_x   = CMP_W'(cfg.high_timeout);
    end

    // Echo high time to Q8 centimetres, saturated
    always_comb
    begin
        prod     = PROD_W'(count_reg) * PROD_W'(uer_pkg::SCALE_Q16);
        scaled   = SC_W'(prod >> uer_pkg::DIST_SHIFT);
        dist_sat = (scaled > SC_W'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_W'(uer_pkg::DIST_MAX)
                                                       : scaled[uer_pkg::DIST_W-1:0];
    end

    // Next state and result of this tick
    always_comb
    begin
        phase_next        = phase_reg;
        count_next        = count_reg;
        res.trigger_level = 1'b0;
        res.busy_res      = 1'b0;
        res.done_res      = 1'b0;
        res.status        = uer_pkg::ST_OK;
        res.distance_q8   = '0;
        unique case (phase_reg)
            uer_pkg::PH_IDLE:
            begin
                if (start_req)
                begin
                    res.trigger_level = 1'b1;
                    res.busy_res      = 1'b1;
                    // a trigger length of one or less ends on this tick
                    if (cfg.trigger_ticks <= uer_pkg::TRIG_W'(1))
                    begin
                        phase_next = uer_pkg::PH_WAIT;
                        count_next = '0;
                    end
                    else
                    begin
                        phase_next = uer_pkg::PH_TRIG;
                        count_next = CNT_ONE;
                    end
                end
            end
            uer_pkg::PH_TRIG:
            begin
                res.trigger_level = 1'b1;
                res.busy_res      = 1'b1;
                if (bumped_x >= trig_x || at_max)
                begin
                    phase_next = uer_pkg::PH_WAIT;
                    count_next = '0;
                end
                else
                begin
                    count_next = bumped;
                end
            end
            uer_pkg::PH_WAIT:
            begin
                if (echo_level)
                begin
                    if (cfg.high_timeout <= uer_pkg::TIMEOUT_W'(1))
                    begin
                        res.done_res = 1'b1;
                        res.status   = uer_pkg::ST_RANGE;
                        phase_next   = uer_pkg::PH_IDLE;
                        count_next   = '0;
                    end
                    else
                    begin
                        res.busy_res = 1'b1;
                        phase_next   = uer_pkg::PH_HIGH;
                        count_next   = CNT_ONE;
                    end
                end
                else if (bumped_x > rise_x || at_max)
                begin
                    res.done_res = 1'b1;
                    res.status   = uer_pkg::ST_NO_ECHO;
                    phase_next   = uer_pkg::PH_IDLE;
                    count_next   = '0;
                end
                else
                begin
                    res.busy_res = 1'b1;
                    count_next   = bumped;
                end
            end
            uer_pkg::PH_HIGH:
            begin
                if (echo_level)
                begin
                    if (bumped_x >= high_x || at_max)
                    begin
                        res.done_res = 1'b1;
                        res.status   = uer_pkg::ST_RANGE;
                        phase_next   = uer_pkg::PH_IDLE;
                        count_next   = '0;
                    end
                    else
                    begin
                        res.busy_res = 1'b1;
                        count_next   = bumped;
                    end
                end
                else
                begin
                    res.done_res    = 1'b1;
                    res.status      = uer_pkg::ST_OK;
                    res.distance_q8 = dist_sat;
                    phase_next      = uer_pkg::PH_IDLE;
                    count_next      = '0;
                end
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
                count_next = '0;
            end
        endcase
    end

    // State registers, advanced only on an accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uer_pkg::PH_IDLE;
            count_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/uer_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_skid: two-entry result buffer
// Registers each result item and holds one more while the receiver stalls.
// ----------------------------------------------------------------------------
module uer_skid (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire uer_pkg::result_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output uer_pkg::result_t      out_data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    uer_pkg::result_t main_data_reg, main_data_next;
    uer_pkg::result_t skid_data_reg, skid_data_next;
    logic             push;
    logic             pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    // Buffer next state
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // held item moves up once the head is taken
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_data_next  = in_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: time-of-flight ranging controller
// Drives the trigger pulse, times the echo and reports distance or an error.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on s_axis is one microsecond tick carrying start_req and the
//   sampled echo level. Each accepted tick yields exactly one item on m_axis:
//   trigger level, busy, done, status and the distance in Q8 centimetres.
//   Ticks should be fed without gaps for accurate timing; the block counts
//   items, not clock cycles.
//   Throughput: one tick per cycle while s_axis_tready is high. Each result
//   item is registered in the buffer before it is valid on m_axis; the
//   distance multiply by 1114 sits between the counter and that buffer.
//   Stall: results go into a two-entry buffer; s_axis_tready stays high while
//   the receiver stalls for one item and drops when both entries are full.
//   Configuration: cfg_we writes register cfg_index (0 trigger_ticks,
//   1 rise_timeout, 2 high_timeout) with cfg_data; write only while idle.
//   Reset: rst_n clears the phase to idle, the counter to zero, empties the
//   buffer and loads the register defaults (20, 10000, 60000).
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // bit 0 start_req, bit 1 echo_level
    input  wire logic [uer_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // bit 0 trigger_level, bit 1 busy_res, bit 2 done_res, bits 4:3 status,
    // bits 22:5 distance_q8
    output logic [uer_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic                            cfg_we,
    input  wire logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [uer_pkg::CFG_DAT_W-1:0]   cfg_data
);

    uer_pkg::cfg_t    cfg_reg;
    uer_pkg::result_t core_res;
    uer_pkg::result_t out_res;
    logic             take;

    assign take = s_axis_tvalid && s_axis_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks <= uer_pkg::TRIGGER_TICKS_RST;
            cfg_reg.rise_timeout  <= uer_pkg::RISE_TIMEOUT_RST;
            cfg_reg.high_timeout  <= uer_pkg::HIGH_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                uer_pkg::REG_TRIGGER_TICKS:
                    cfg_reg.trigger_ticks <= cfg_data[uer_pkg::TRIG_W-1:0];
                uer_pkg::REG_RISE_TIMEOUT:
                    cfg_reg.rise_timeout  <= cfg_data[uer_pkg::TIMEOUT_W-1:0];
                uer_pkg::REG_HIGH_TIMEOUT:
                    cfg_reg.high_timeout  <= cfg_data[uer_pkg::TIMEOUT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Ranging state machine
    uer_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .take       (take),
        .start_req  (s_axis_tdata[0]),
        .echo_level (s_axis_tdata[1]),
        .res        (core_res)
    );

    // Result register and stall buffer
    uer_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (core_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    // Pack the result item, low field first
    assign m_axis_tdata = {1'b0, out_res.distance_q8, out_res.status, out_res.done_res,
                           out_res.busy_res, out_res.trigger_level};

endmodule
`default_nettype wire
